>>> sv/tpcpw_pkg.sv
// shared types and constants for the tft panel command and pixel writer
// no dependencies; used by tpcpw_ctrl, tpcpw_out_reg and the top level
package tpcpw_pkg;

    typedef enum logic [1:0] {
        FUNC_DATA  = 2'd0,
        FUNC_CMD   = 2'd1,
        FUNC_RESET = 2'd2
    } t_func;

    localparam logic [15:0] CMD_SWRESET = 16'h0001;
    localparam logic [15:0] CMD_CASET   = 16'h002A;
    localparam logic [15:0] CMD_PASET   = 16'h002B;
    localparam logic [15:0] CMD_RAMWR   = 16'h002C;
    localparam logic [15:0] CMD_MADCTL  = 16'h0036;

    // orientation bits
    localparam int unsigned ORI_MY = 7;
    localparam int unsigned ORI_MX = 6;
    localparam int unsigned ORI_MV = 5;

    localparam logic [2:0] PARAM_FULL = 3'd4;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // rgb565 to rgb888 by bit replication
    function automatic t_rgb expand_565(input logic [15:0] c);
        t_rgb v;
        v.red   = {c[15:11], c[15:13]};
        v.green = {c[10:5], c[10:9]};
        v.blue  = {c[4:0], c[4:2]};
        return v;
    endfunction

endpackage

>>> sv/tpcpw_ctrl.sv
// command decode, window and cursor state, orientation transform
// depends on tpcpw_pkg
module tpcpw_ctrl #(
    parameter int PANEL_WIDTH  = 320,
    parameter int PANEL_HEIGHT = 480,
    parameter int X_W          = 9,
    parameter int Y_W          = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [1:0]         i_func,
    input  logic [15:0]        i_word,
    output logic               o_pix_valid,
    output logic [X_W-1:0]     o_pix_x,
    output logic [Y_W-1:0]     o_pix_y,
    output tpcpw_pkg::t_rgb    o_rgb
);

    localparam logic [15:0] W_LAST = 16'(PANEL_WIDTH - 1);
    localparam logic [15:0] H_LAST = 16'(PANEL_HEIGHT - 1);
    localparam logic [15:0] W16    = 16'(PANEL_WIDTH);
    localparam logic [15:0] H16    = 16'(PANEL_HEIGHT);

    logic [15:0] r_cmd, n_cmd;
    logic [2:0]  r_cnt, n_cnt;
    logic [7:0]  r_bytes [4];
    logic [7:0]  n_bytes [4];
    logic [15:0] r_col_start, n_col_start, r_col_end, n_col_end;
    logic [15:0] r_row_start, n_row_start, r_row_end, n_row_end;
    logic [15:0] r_cur_col, n_cur_col, r_cur_row, n_cur_row;
    logic [7:0]  r_ori, n_ori;
    logic        n_clear;

    logic [15:0] x_sw, y_sw, x_t, y_t;
    logic        ramwr_data;

    assign ramwr_data = (tpcpw_pkg::t_func'(i_func) == tpcpw_pkg::FUNC_DATA)
                        && (r_cmd == tpcpw_pkg::CMD_RAMWR);

    always_comb begin
        x_sw = r_ori[tpcpw_pkg::ORI_MV] ? r_cur_row : r_cur_col;
        y_sw = r_ori[tpcpw_pkg::ORI_MV] ? r_cur_col : r_cur_row;
        y_t  = r_ori[tpcpw_pkg::ORI_MY] ? (H_LAST - y_sw) : y_sw;
        x_t  = r_ori[tpcpw_pkg::ORI_MX] ? x_sw : (W_LAST - x_sw);
    end

    assign o_pix_valid = ramwr_data && (x_t < W16) && (y_t < H16);
    assign o_pix_x     = x_t[X_W-1:0];
    assign o_pix_y     = y_t[Y_W-1:0];
    assign o_rgb       = tpcpw_pkg::expand_565(i_word);

    // parameter byte collection, saturating at four
    task automatic collect();
        if (r_cnt < tpcpw_pkg::PARAM_FULL) begin
            n_bytes[r_cnt[1:0]] = i_word[7:0];
            n_cnt = r_cnt + 3'd1;
        end
    endtask

    always_comb begin
        n_cmd       = r_cmd;
        n_cnt       = r_cnt;
        n_bytes     = r_bytes;
        n_col_start = r_col_start;
        n_col_end   = r_col_end;
        n_row_start = r_row_start;
        n_row_end   = r_row_end;
        n_cur_col   = r_cur_col;
        n_cur_row   = r_cur_row;
        n_ori       = r_ori;
        n_clear     = 1'b0;
        case (tpcpw_pkg::t_func'(i_func))
            tpcpw_pkg::FUNC_RESET: begin
                n_clear = 1'b1;
            end
            tpcpw_pkg::FUNC_CMD: begin
                n_cmd = i_word;
                n_cnt = 3'd0;
                if (i_word == tpcpw_pkg::CMD_SWRESET) begin
                    n_clear = 1'b1;
                end else if (i_word == tpcpw_pkg::CMD_RAMWR) begin
                    n_cur_col = r_col_start;
                    n_cur_row = r_row_start;
                end
            end
            tpcpw_pkg::FUNC_DATA: begin
                case (r_cmd)
                    tpcpw_pkg::CMD_CASET: begin
                        collect();
                        if (n_cnt >= tpcpw_pkg::PARAM_FULL) begin
                            n_col_start = {n_bytes[0], n_bytes[1]};
                            n_col_end   = {n_bytes[2], n_bytes[3]};
                        end
                    end
                    tpcpw_pkg::CMD_PASET: begin
                        collect();
                        if (n_cnt >= tpcpw_pkg::PARAM_FULL) begin
                            n_row_start = {n_bytes[0], n_bytes[1]};
                            n_row_end   = {n_bytes[2], n_bytes[3]};
                        end
                    end
                    tpcpw_pkg::CMD_MADCTL: begin
                        if (r_cnt == 3'd0) begin
                            n_ori = i_word[7:0];
                        end
                        collect();
                    end
                    tpcpw_pkg::CMD_RAMWR: begin
                        n_cnt = 3'd0;
                        // step through the window, wrap to next row
                        if (r_cur_col < r_col_end) begin
                            n_cur_col = r_cur_col + 16'd1;
                        end else begin
                            n_cur_col = r_col_start;
                            n_cur_row = r_cur_row + 16'd1;
                        end
                    end
                    default: begin
                        n_cnt = 3'd0;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && n_clear)) begin
            r_cmd       <= 16'd0;
            r_cnt       <= 3'd0;
            r_col_start <= 16'd0;
            r_col_end   <= 16'd0;
            r_row_start <= 16'd0;
            r_row_end   <= 16'd0;
            r_cur_col   <= 16'd0;
            r_cur_row   <= 16'd0;
            r_ori       <= 8'd0;
        end else if (i_step) begin
            r_cmd       <= n_cmd;
            r_cnt       <= n_cnt;
            r_col_start <= n_col_start;
            r_col_end   <= n_col_end;
            r_row_start <= n_row_start;
            r_row_end   <= n_row_end;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_ori       <= n_ori;
        end
    end

    // parameter bytes are only read after being written
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_bytes <= n_bytes;
        end
    end

endmodule

>>> sv/tpcpw_out_reg.sv
// result register holding one pixel until the downstream side takes it
// depends on tpcpw_pkg
module tpcpw_out_reg #(
    parameter int X_W = 9,
    parameter int Y_W = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_pix_valid,
    input  logic [X_W-1:0]     i_pix_x,
    input  logic [Y_W-1:0]     i_pix_y,
    input  tpcpw_pkg::t_rgb    i_rgb,
    input  logic               i_ready,
    output logic               o_free,
    output logic               o_valid,
    output logic [X_W-1:0]     o_pixel_x,
    output logic [Y_W-1:0]     o_pixel_y,
    output tpcpw_pkg::t_rgb    o_rgb
);

    logic               r_valid;
    logic [X_W-1:0]     r_x;
    logic [Y_W-1:0]     r_y;
    tpcpw_pkg::t_rgb    r_rgb;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load && i_pix_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load && i_pix_valid) begin
            r_x   <= i_pix_x;
            r_y   <= i_pix_y;
            r_rgb <= i_rgb;
        end
    end

    assign o_valid   = r_valid;
    assign o_pixel_x = r_x;
    assign o_pixel_y = r_y;
    assign o_rgb     = r_rgb;

endmodule

>>> sv/tft_panel_command_pixel_writer.sv
// tft panel command and pixel writer: input register, decode, result register
// throughput: one request per cycle, limited only by output stalls
// reset: synchronous active-low i_rst_n clears window, cursor, command and pipeline
module tft_panel_command_pixel_writer #(
    parameter int PANEL_WIDTH  = 320,
    parameter int PANEL_HEIGHT = 480
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_func,
    input  logic [15:0]                       i_word,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [$clog2(PANEL_WIDTH)-1:0]    o_pixel_x,
    output logic [$clog2(PANEL_HEIGHT)-1:0]   o_pixel_y,
    output logic [7:0]                        o_red,
    output logic [7:0]                        o_green,
    output logic [7:0]                        o_blue
);

    localparam int X_W = $clog2(PANEL_WIDTH);
    localparam int Y_W = $clog2(PANEL_HEIGHT);

    logic           r_in_valid;
    logic [1:0]     r_func;
    logic [15:0]    r_word;
    logic           adv;
    logic           step;

    logic               pix_valid;
    logic [X_W-1:0]     pix_x;
    logic [Y_W-1:0]     pix_y;
    tpcpw_pkg::t_rgb    pix_rgb;
    tpcpw_pkg::t_rgb    out_rgb;

    assign step    = r_in_valid && adv;
    assign o_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_func <= i_func;
            r_word <= i_word;
        end
    end

    tpcpw_ctrl #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .X_W          (X_W),
        .Y_W          (Y_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_func      (r_func),
        .i_word      (r_word),
        .o_pix_valid (pix_valid),
        .o_pix_x     (pix_x),
        .o_pix_y     (pix_y),
        .o_rgb       (pix_rgb)
    );

    tpcpw_out_reg #(
        .X_W (X_W),
        .Y_W (Y_W)
    ) u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (r_in_valid),
        .i_pix_valid (pix_valid),
        .i_pix_x     (pix_x),
        .i_pix_y     (pix_y),
        .i_rgb       (pix_rgb),
        .i_ready     (i_ready),
        .o_free      (adv),
        .o_valid     (o_valid),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_rgb       (out_rgb)
    );

    assign o_red   = out_rgb.red;
    assign o_green = out_rgb.green;
    assign o_blue  = out_rgb.blue;

endmodule

>>> tb/sv/tpcpw_pixel_checker.sv
// pixel checker for the tft panel command and pixel writer: watches both channels,
// tracks command, window, cursor and orientation, and compares every written pixel
// depends on tpcpw_pkg for the func codes, command codes and orientation bit indexes
module tpcpw_pixel_checker #(
    parameter int PANEL_WIDTH  = 320,
    parameter int PANEL_HEIGHT = 480
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_req_valid,
    input  logic                              i_req_ready,
    input  logic [1:0]                        i_func,
    input  logic [15:0]                       i_word,
    input  logic                              i_pix_valid,
    input  logic                              i_pix_ready,
    input  logic [$clog2(PANEL_WIDTH)-1:0]    i_pixel_x,
    input  logic [$clog2(PANEL_HEIGHT)-1:0]   i_pixel_y,
    input  logic [7:0]                        i_red,
    input  logic [7:0]                        i_green,
    input  logic [7:0]                        i_blue,
    output int                                o_fail_count,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int XW = $clog2(PANEL_WIDTH);
    localparam int YW = $clog2(PANEL_HEIGHT);

    typedef struct packed {
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        logic [7:0]    red;
        logic [7:0]    green;
        logic [7:0]    blue;
    } t_panel_pixel;

    t_panel_pixel expected_pixels[$];
    int           fail_count = 0;

    logic [15:0] active_cmd;
    logic [2:0]  param_cnt;
    logic [7:0]  param_byte [4];
    logic [15:0] col_lo, col_hi, row_lo, row_hi;
    logic [15:0] cur_col, cur_row;
    logic [7:0]  orient;

    function automatic void clear_state();
        active_cmd = '0;
        param_cnt  = '0;
        for (int i = 0; i < 4; i++) param_byte[i] = '0;
        col_lo  = '0;
        col_hi  = '0;
        row_lo  = '0;
        row_hi  = '0;
        cur_col = '0;
        cur_row = '0;
        orient  = '0;
    endfunction

    // only the low byte of a parameter word counts, and only the first four
    function automatic void take_param(input logic [15:0] w);
        if (param_cnt < tpcpw_pkg::PARAM_FULL) begin
            param_byte[param_cnt[1:0]] = w[7:0];
            param_cnt = param_cnt + 3'd1;
        end
    endfunction

    function automatic void predict_request(input logic [1:0] fn, input logic [15:0] w);
        logic [15:0]  px, py, held;
        t_panel_pixel pix;
        case (fn)
            tpcpw_pkg::FUNC_RESET: clear_state();
            tpcpw_pkg::FUNC_CMD: begin
                active_cmd = w;
                param_cnt  = '0;
                if (w == tpcpw_pkg::CMD_SWRESET) begin
                    clear_state();
                end else if (w == tpcpw_pkg::CMD_RAMWR) begin
                    cur_col = col_lo;
                    cur_row = row_lo;
                end
            end
            tpcpw_pkg::FUNC_DATA: begin
                case (active_cmd)
                    tpcpw_pkg::CMD_CASET: begin
                        take_param(w);
                        if (param_cnt >= tpcpw_pkg::PARAM_FULL) begin
                            col_lo = {param_byte[0], param_byte[1]};
                            col_hi = {param_byte[2], param_byte[3]};
                        end
                    end
                    tpcpw_pkg::CMD_PASET: begin
                        take_param(w);
                        if (param_cnt >= tpcpw_pkg::PARAM_FULL) begin
                            row_lo = {param_byte[0], param_byte[1]};
                            row_hi = {param_byte[2], param_byte[3]};
                        end
                    end
                    tpcpw_pkg::CMD_MADCTL: begin
                        if (param_cnt == '0) orient = w[7:0];
                        take_param(w);
                    end
                    tpcpw_pkg::CMD_RAMWR: begin
                        param_cnt = '0;
                        px = cur_col;
                        py = cur_row;
                        if (orient[tpcpw_pkg::ORI_MV]) begin
                            held = px;
                            px   = py;
                            py   = held;
                        end
                        if (orient[tpcpw_pkg::ORI_MY]) py = 16'(PANEL_HEIGHT - 1) - py;
                        // x mirror applies when mx is clear
                        if (!orient[tpcpw_pkg::ORI_MX]) px = 16'(PANEL_WIDTH - 1) - px;
                        if (px < PANEL_WIDTH && py < PANEL_HEIGHT) begin
                            pix.x     = px[XW-1:0];
                            pix.y     = py[YW-1:0];
                            pix.red   = {w[15:11], w[15:13]};
                            pix.green = {w[10:5], w[10:9]};
                            pix.blue  = {w[4:0], w[4:2]};
                            expected_pixels.push_back(pix);
                        end
                        // cursor advances even for off-panel pixels
                        if (cur_col < col_hi) begin
                            cur_col = cur_col + 16'd1;
                        end else begin
                            cur_col = col_lo;
                            cur_row = cur_row + 16'd1;
                        end
                    end
                    default: param_cnt = '0;
                endcase
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_panel_pixel want;
        if (!i_rst_n) begin
            clear_state();
            expected_pixels.delete();
        end else begin
            // results first: a pixel accepted now never comes from this edge's request
            if (i_pix_valid && i_pix_ready) begin
                if (expected_pixels.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected pixel x=%0d y=%0d rgb=%02h%02h%02h",
                                 $realtime, i_pixel_x, i_pixel_y, i_red, i_green, i_blue);
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_pixel_x !== want.x || i_pixel_y !== want.y ||
                        i_red !== want.red || i_green !== want.green ||
                        i_blue !== want.blue) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: exp %0d,%0d %h%h%h, got %0d,%0d %h%h%h",
                                     $realtime, want.x, want.y, want.red, want.green,
                                     want.blue, i_pixel_x, i_pixel_y, i_red, i_green,
                                     i_blue);
                    end
                end
            end
            if (i_req_valid && i_req_ready) predict_request(i_func, i_word);
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_pixels.size();
    end

endmodule

>>> tb/sv/tb.sv
// testbench top for the tft panel command and pixel writer: clock, reset, request
// stimulus with random gaps, random output stalls, and the final verdict
// depends on tpcpw_pkg, the block itself and tpcpw_pixel_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PANEL_WIDTH  = 320;
    localparam int PANEL_HEIGHT = 480;
    localparam int REQ_TARGET   = 1925;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [1:0]  i_func  = tpcpw_pkg::FUNC_DATA;
    logic [15:0] i_word  = '0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [$clog2(PANEL_WIDTH)-1:0]  o_pixel_x;
    logic [$clog2(PANEL_HEIGHT)-1:0] o_pixel_y;
    logic [7:0]  o_red, o_green, o_blue;

    int fail_count;
    int pending;
    int reqs_sent = 0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;

    always #6 i_clk = ~i_clk;

    tft_panel_command_pixel_writer #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_func    (i_func),
        .i_word    (i_word),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_pixel_x (o_pixel_x),
        .o_pixel_y (o_pixel_y),
        .o_red     (o_red),
        .o_green   (o_green),
        .o_blue    (o_blue)
    );

    tpcpw_pixel_checker #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_ready  (o_ready),
        .i_func       (i_func),
        .i_word       (i_word),
        .i_pix_valid  (o_valid),
        .i_pix_ready  (i_ready),
        .i_pixel_x    (o_pixel_x),
        .i_pixel_y    (o_pixel_y),
        .i_red        (o_red),
        .i_green      (o_green),
        .i_blue       (o_blue),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // called at a rising edge; returns at the edge that accepts the request
    task automatic send_request(input tpcpw_pkg::t_func fn, input logic [15:0] w);
        int gap;
        if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= fn;
        i_word  <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        reqs_sent++;
    endtask

    // window command with n_bytes parameter words, random upper byte
    task automatic send_window(input logic [15:0] cmd, input logic [15:0] lo,
                               input logic [15:0] hi, input int n_bytes);
        logic [7:0] pbyte;
        send_request(tpcpw_pkg::FUNC_CMD, cmd);
        for (int i = 0; i < n_bytes; i++) begin
            case (i)
                0:       pbyte = lo[15:8];
                1:       pbyte = lo[7:0];
                2:       pbyte = hi[15:8];
                3:       pbyte = hi[7:0];
                default: pbyte = 8'($urandom);
            endcase
            send_request(tpcpw_pkg::FUNC_DATA, {8'($urandom), pbyte});
        end
    endtask

    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
            stall = recv_calm ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    initial begin
        int          pick, n, drain;
        bit          stuck;
        logic [15:0] cmd, lo, hi;
        int          span;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full-width columns with an extra byte, bottom two rows
        send_request(tpcpw_pkg::FUNC_CMD, tpcpw_pkg::CMD_SWRESET);
        send_window(tpcpw_pkg::CMD_CASET, 16'h0000, 16'h013F, 5);
        send_window(tpcpw_pkg::CMD_PASET, 16'h01DE, 16'h01DF, 4);
        // my and mx set, later madctl words ignored
        send_request(tpcpw_pkg::FUNC_CMD, tpcpw_pkg::CMD_MADCTL);
        send_request(tpcpw_pkg::FUNC_DATA, 16'h5AC0);
        send_request(tpcpw_pkg::FUNC_DATA, 16'hFF20);
        send_request(tpcpw_pkg::FUNC_CMD, tpcpw_pkg::CMD_RAMWR);
        send_request(tpcpw_pkg::FUNC_DATA, 16'hFFFF);
        send_request(tpcpw_pkg::FUNC_DATA, 16'h0000);
        // swap only: row 478 lands off the panel
        send_request(tpcpw_pkg::FUNC_CMD, tpcpw_pkg::CMD_MADCTL);
        send_request(tpcpw_pkg::FUNC_DATA, 16'h0020);
        send_request(tpcpw_pkg::FUNC_CMD, tpcpw_pkg::CMD_RAMWR);
        send_request(tpcpw_pkg::FUNC_DATA, 16'hF81F);
        send_request(tpcpw_pkg::FUNC_RESET, 16'hFFFF);
        // data for an unknown command is dropped
        send_request(tpcpw_pkg::FUNC_CMD, 16'h1234);
        send_request(tpcpw_pkg::FUNC_DATA, 16'hABCD);
        send_request(tpcpw_pkg::FUNC_CMD, tpcpw_pkg::CMD_RAMWR);
        send_request(tpcpw_pkg::FUNC_DATA, 16'h07E0);

        while (reqs_sent < REQ_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 30 || (pick >= 80 && pick < 85)) begin
                cmd  = ($urandom_range(0, 1) == 0) ? tpcpw_pkg::CMD_CASET
                                                   : tpcpw_pkg::CMD_PASET;
                span = (cmd == tpcpw_pkg::CMD_CASET) ? PANEL_WIDTH : PANEL_HEIGHT;
                lo   = 16'($urandom_range(0, span - 1));
                hi   = lo + 16'($urandom_range(0, 15));
                case ($urandom_range(0, 9))
                    0: begin
                        lo = 16'($urandom);
                        hi = 16'($urandom);
                    end
                    1: hi = lo - 16'($urandom_range(1, 8));
                    2: begin
                        lo = '0;
                        hi = 16'(span - 1);
                    end
                    default: ;
                endcase
                if (pick >= 80) n = $urandom_range(1, 3);
                else if ($urandom_range(0, 4) == 0) n = $urandom_range(5, 6);
                else n = 4;
                send_window(cmd, lo, hi, n);
            end else if (pick < 40) begin
                send_request(tpcpw_pkg::FUNC_CMD, tpcpw_pkg::CMD_MADCTL);
                send_request(tpcpw_pkg::FUNC_DATA, 16'($urandom));
                if ($urandom_range(0, 2) == 0)
                    send_request(tpcpw_pkg::FUNC_DATA, 16'($urandom));
            end else if (pick < 80) begin
                send_request(tpcpw_pkg::FUNC_CMD, tpcpw_pkg::CMD_RAMWR);
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                                : $urandom_range(1, 24);
                repeat (n) send_request(tpcpw_pkg::FUNC_DATA, 16'($urandom));
            end else if (pick < 90) begin
                send_request(tpcpw_pkg::FUNC_CMD, 16'($urandom));
                repeat ($urandom_range(0, 3))
                    send_request(tpcpw_pkg::FUNC_DATA, 16'($urandom));
            end else if (pick < 94) begin
                repeat ($urandom_range(1, 3))
                    send_request(tpcpw_pkg::FUNC_DATA, 16'($urandom));
            end else if (pick < 97) begin
                send_request(tpcpw_pkg::FUNC_CMD, tpcpw_pkg::CMD_SWRESET);
            end else begin
                send_request(tpcpw_pkg::FUNC_RESET, 16'($urandom));
            end
        end
        i_valid <= 1'b0;

        drain = 0;
        do begin
            @(posedge i_clk);
            drain++;
        end while (pending != 0 && drain < 5000);
        stuck = (pending != 0);
        if (stuck) $display("pixels still outstanding at end: %0d", pending);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && !stuck) begin
            $display("** tft_panel_command_pixel_writer: PASSED **");
        end else begin
            $display("** tft_panel_command_pixel_writer: FAILED **");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("timeout waiting for requests or pixels");
        $display("** tft_panel_command_pixel_writer: FAILED **");
        $finish;
    end

endmodule
